/* rtl/mcpi_pkg.sv */
// Shared types and constants for the motor current PI / PWM controller.
// Used by mcpi_ctrl, mcpi_dp and motor_current_pi_pwm_controller.
package mcpi_pkg;

    // field widths
    localparam int CMD_W      = 2;
    localparam int MODE_W     = 3;
    localparam int CUR_W      = 16;
    localparam int DREQ_W     = 8;
    localparam int IDX_W      = 7;
    localparam int DUTY_W     = 7;
    localparam int CMP_W      = 17;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 20;
    localparam int AMP_W      = 15;
    localparam int INTEG_W    = 21;
    localparam int TICK_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // stream word widths
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 64;

    // commands
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 2'd0,
        CMD_MODE_SEL = 2'd1,
        CMD_SET_DUTY = 2'd2,
        CMD_READ     = 2'd3
    } t_cmd;

    // operating modes (five to seven are inert)
    localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PWM   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TEST  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HOLD  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TRACK = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEST_AMP   = 3'd4;

    // reset values
    localparam logic [LIM_W-1:0] LIM_RST     = 20'd100;
    localparam logic [CMP_W-1:0] PERIOD_RST  = 17'd4000;
    localparam logic [AMP_W-1:0] AMP_RST     = 15'd200;
    localparam logic [CMP_W-1:0] COMPARE_RST = 17'd3000;

    // duty limit and square-wave test schedule
    localparam logic [DUTY_W-1:0] DUTY_MAX       = 7'd100;
    localparam logic [TICK_W-1:0] TEST_FLIP_A    = 7'd25;
    localparam logic [TICK_W-1:0] TEST_FLIP_B    = 7'd50;
    localparam logic [TICK_W-1:0] TEST_FLIP_C    = 7'd75;
    localparam logic [TICK_W-1:0] TEST_LAST_TICK = 7'd99;

    // compare = period*duty/100 via reciprocal: floor(x*ceil(2^31/100) >> 31),
    // exact for every x below 2^24
    localparam int CMP_PROD_W = 24;
    localparam int CMP_MUL_W  = 49;
    localparam int CMP_SHIFT  = 31;
    localparam logic [24:0] CMP_RECIP = 25'd21474837;

    // PI arithmetic widths
    localparam int ERR_W   = 17;
    localparam int PPROD_W = 34;
    localparam int IPROD_W = 38;
    localparam int U_W     = 39;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PI_INT,
        ST_PI_MUL,
        ST_PI_SUM,
        ST_CMP_MUL,
        ST_CMP_DIV,
        ST_DONE
    } t_mcpi_state;

    // one input word
    typedef struct packed {
        t_cmd                      cmd;
        logic signed [CUR_W-1:0]   sensed;
        logic signed [CUR_W-1:0]   demanded;
        logic [MODE_W-1:0]         new_mode;
        logic signed [DREQ_W-1:0]  duty_req;
        logic [IDX_W-1:0]          idx;
    } t_in_word;

    // controller -> datapath steps
    typedef struct packed {
        logic latch;
        logic idle_tick;
        logic mode_sel;
        logic set_duty;
        logic rd_rec;
        logic load_ref;
        logic pi_integ;
        logic pi_mul;
        logic pi_sum;
        logic cmp_mul;
        logic cmp_div;
    } t_dp_cmd;

    // datapath -> controller status
    typedef struct packed {
        t_cmd               cmd;
        logic [MODE_W-1:0]  mode;
        logic [TICK_W-1:0]  test_tick;
    } t_dp_status;

    // result word fields
    typedef struct packed {
        logic [CMP_W-1:0]   compare;
        logic               direction;
        logic [DUTY_W-1:0]  duty;
        logic               test_done;
        logic [MODE_W-1:0]  mode;
        logic [CUR_W-1:0]   rec_sensed;
        logic [CUR_W-1:0]   rec_reference;
    } t_result;

endpackage

/* rtl/mcpi_ctrl.sv */
// Sequencer for the motor current controller: one word at a time.
// Depends on mcpi_pkg; drives mcpi_dp through t_dp_cmd.
module mcpi_ctrl
    import mcpi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_free,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_load,
    output t_dp_cmd    o_cmd
);

    t_mcpi_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and step commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_DONE;
                case (i_status.cmd)
                    CMD_TICK: begin
                        if (i_status.mode == MODE_IDLE) begin
                            o_cmd.idle_tick = 1'b1;
                        end else if (i_status.mode == MODE_PWM) begin
                            n_state = ST_CMP_MUL;
                        end else if (i_status.mode == MODE_TEST ||
                                     i_status.mode == MODE_HOLD ||
                                     i_status.mode == MODE_TRACK) begin
                            o_cmd.load_ref = 1'b1;
                            n_state        = ST_PI_INT;
                        end
                    end
                    CMD_MODE_SEL: o_cmd.mode_sel = 1'b1;
                    CMD_SET_DUTY: o_cmd.set_duty = 1'b1;
                    CMD_READ:     o_cmd.rd_rec   = 1'b1;
                    default:      n_state = ST_DONE;
                endcase
            end
            ST_PI_INT: begin
                o_cmd.pi_integ = 1'b1;
                n_state        = ST_PI_MUL;
            end
            ST_PI_MUL: begin
                o_cmd.pi_mul = 1'b1;
                n_state      = ST_PI_SUM;
            end
            ST_PI_SUM: begin
                o_cmd.pi_sum = 1'b1;
                n_state      = ST_CMP_MUL;
            end
            ST_CMP_MUL: begin
                o_cmd.cmp_mul = 1'b1;
                n_state       = ST_CMP_DIV;
            end
            ST_CMP_DIV: begin
                o_cmd.cmp_div = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                // wait for the output register to be free
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

/* rtl/mcpi_dp.sv */
// Datapath: controller state, PI arithmetic, compare scaling and test record.
// Depends on mcpi_pkg; stepped by mcpi_ctrl.
module mcpi_dp
    import mcpi_pkg::*;
#(
    parameter int RECORD_DEPTH   = 128,
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  t_in_word          i_word,
    input  logic [GAIN_W-1:0] i_prop_gain,
    input  logic [GAIN_W-1:0] i_integ_gain,
    input  logic [LIM_W-1:0]  i_integ_limit,
    input  logic [CMP_W-1:0]  i_pwm_period,
    input  logic [AMP_W-1:0]  i_test_amp,
    output t_dp_status        o_status,
    output t_result           o_result
);

    localparam int AW = $clog2(RECORD_DEPTH);

    // latched word and control state
    t_in_word                   r_in;
    logic [MODE_W-1:0]          r_mode;
    logic signed [INTEG_W-1:0]  r_integ;
    logic [DUTY_W-1:0]          r_duty;
    logic                       r_dir;
    logic [CMP_W-1:0]           r_compare;
    logic [TICK_W-1:0]          r_test_tick;
    logic                       r_ref_neg;
    logic                       r_finished;

    // pipeline payload
    logic signed [CUR_W-1:0]    r_ref;
    logic signed [ERR_W-1:0]    r_err;
    logic signed [INTEG_W-1:0]  r_ivalue;
    logic signed [PPROD_W-1:0]  r_pprod;
    logic signed [IPROD_W-1:0]  r_iprod;
    logic [CMP_PROD_W-1:0]      r_cprod;

    // record memory
    logic [CUR_W-1:0] r_sensed_mem [RECORD_DEPTH];
    logic [CUR_W-1:0] r_ref_mem    [RECORD_DEPTH];
    logic [CUR_W-1:0] r_rd_sensed;
    logic [CUR_W-1:0] r_rd_ref;
    logic             r_rd_ok;

    logic signed [ERR_W-1:0]    w_err;
    logic signed [INTEG_W:0]    w_isum;
    logic signed [INTEG_W:0]    w_lim_pos;
    logic signed [INTEG_W:0]    w_lim_neg;
    logic signed [INTEG_W:0]    w_isel;
    logic signed [INTEG_W-1:0]  w_iclamp;
    logic signed [CUR_W-1:0]    w_amp;
    logic signed [CUR_W-1:0]    w_test_ref;
    logic signed [U_W-1:0]      w_u;
    logic [U_W-1:0]             w_umag;
    logic [U_W-1:0]             w_ushift;
    logic [DUTY_W-1:0]          w_duty_pi;
    logic [DUTY_W-1:0]          w_duty_set;
    logic [CMP_PROD_W-1:0]      w_cprod;
    logic [CMP_MUL_W-1:0]       w_cmul;
    logic                       w_in_test;
    logic                       w_flip;
    logic                       w_last;
    logic                       w_wr_ok;
    logic                       w_rd_ok;
    logic [AW-1:0]              w_wr_addr;
    logic [AW-1:0]              w_rd_addr;

    // error and clamped integral
    assign w_err     = $signed({r_ref[CUR_W-1], r_ref})
                     - $signed({r_in.sensed[CUR_W-1], r_in.sensed});
    assign w_isum    = $signed({r_integ[INTEG_W-1], r_integ})
                     + $signed({{(INTEG_W+1-ERR_W){w_err[ERR_W-1]}}, w_err});
    assign w_lim_pos = $signed({2'b00, i_integ_limit});
    assign w_lim_neg = -w_lim_pos;

    always_comb begin
        if (w_isum > w_lim_pos) begin
            w_isel = w_lim_pos;
        end else if (w_isum < w_lim_neg) begin
            w_isel = w_lim_neg;
        end else begin
            w_isel = w_isum;
        end
    end
    assign w_iclamp = w_isel[INTEG_W-1:0];

    // square-wave reference
    assign w_amp      = $signed({1'b0, i_test_amp});
    assign w_test_ref = r_ref_neg ? -w_amp : w_amp;

    // PI output: sum, magnitude, drop fraction, saturate
    assign w_u      = $signed({{(U_W-PPROD_W){r_pprod[PPROD_W-1]}}, r_pprod})
                    + $signed({{(U_W-IPROD_W){r_iprod[IPROD_W-1]}}, r_iprod});
    assign w_umag   = w_u[U_W-1] ? U_W'(-w_u) : U_W'(w_u);
    assign w_ushift = w_umag >> GAIN_FRAC_BITS;
    assign w_duty_pi = (w_ushift > U_W'(DUTY_MAX)) ? DUTY_MAX : w_ushift[DUTY_W-1:0];

    // directly set duty, saturated to plus or minus 100
    always_comb begin
        if (r_in.duty_req > 8'sd100 || r_in.duty_req < -8'sd100) begin
            w_duty_set = DUTY_MAX;
        end else if (r_in.duty_req[DREQ_W-1]) begin
            w_duty_set = DUTY_W'(-r_in.duty_req);
        end else begin
            w_duty_set = r_in.duty_req[DUTY_W-1:0];
        end
    end

    // compare scaling
    assign w_cprod = CMP_PROD_W'(i_pwm_period) * CMP_PROD_W'(r_duty);
    assign w_cmul  = CMP_MUL_W'(r_cprod) * CMP_MUL_W'(CMP_RECIP);

    // test schedule
    assign w_in_test = (r_mode == MODE_TEST);
    assign w_flip    = (r_test_tick == TEST_FLIP_A) || (r_test_tick == TEST_FLIP_B) ||
                       (r_test_tick == TEST_FLIP_C);
    assign w_last    = (r_test_tick == TEST_LAST_TICK);
    assign w_wr_ok   = (32'(r_test_tick) < RECORD_DEPTH);
    assign w_rd_ok   = (32'(r_in.idx) < RECORD_DEPTH);
    assign w_wr_addr = AW'(r_test_tick);
    assign w_rd_addr = AW'(r_in.idx);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_integ     <= '0;
            r_duty      <= '0;
            r_dir       <= 1'b0;
            r_compare   <= COMPARE_RST;
            r_test_tick <= '0;
            r_ref_neg   <= 1'b0;
            r_finished  <= 1'b0;
        end else begin
            if (i_cmd.idle_tick) begin
                r_compare <= '0;
            end
            if (i_cmd.mode_sel) begin
                r_mode <= r_in.new_mode;
                if (r_in.new_mode == MODE_TEST) begin
                    r_finished <= 1'b0;
                end
            end
            if (i_cmd.set_duty) begin
                r_duty <= w_duty_set;
                r_dir  <= r_in.duty_req[DREQ_W-1];
            end
            if (i_cmd.pi_integ) begin
                r_integ <= (w_in_test && w_last) ? '0 : w_iclamp;
                if (w_in_test) begin
                    r_finished <= w_last;
                    if (w_flip) begin
                        r_ref_neg <= ~r_ref_neg;
                    end
                    if (w_last) begin
                        r_mode      <= MODE_IDLE;
                        r_test_tick <= '0;
                    end else begin
                        r_test_tick <= r_test_tick + 1'b1;
                    end
                end
            end
            if (i_cmd.pi_sum) begin
                r_duty <= w_duty_pi;
                r_dir  <= w_u[U_W-1];
            end
            if (i_cmd.cmp_div) begin
                r_compare <= w_cmul[CMP_SHIFT +: CMP_W];
            end
        end
    end

    // arithmetic pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in <= i_word;
        end
        if (i_cmd.load_ref) begin
            r_ref <= w_in_test ? w_test_ref : r_in.demanded;
        end
        if (i_cmd.pi_integ) begin
            r_err    <= w_err;
            r_ivalue <= w_iclamp;
        end
        if (i_cmd.pi_mul) begin
            r_pprod <= $signed({1'b0, i_prop_gain}) * r_err;
            r_iprod <= $signed({1'b0, i_integ_gain}) * r_ivalue;
        end
        if (i_cmd.cmp_mul) begin
            r_cprod <= w_cprod;
        end
    end

    // record memory: written on test ticks, read with registered data
    always_ff @(posedge i_clk) begin
        if (i_cmd.pi_integ && w_in_test && w_wr_ok) begin
            r_sensed_mem[w_wr_addr] <= r_in.sensed;
            r_ref_mem[w_wr_addr]    <= r_ref;
        end
        if (i_cmd.rd_rec) begin
            r_rd_sensed <= r_sensed_mem[w_rd_addr];
            r_rd_ref    <= r_ref_mem[w_rd_addr];
            r_rd_ok     <= w_rd_ok;
        end
    end

    // status and result
    assign o_status.cmd       = r_in.cmd;
    assign o_status.mode      = r_mode;
    assign o_status.test_tick = r_test_tick;

    assign o_result.compare       = r_compare;
    assign o_result.direction     = r_dir;
    assign o_result.duty          = r_duty;
    assign o_result.test_done     = r_finished;
    assign o_result.mode          = r_mode;
    assign o_result.rec_sensed    = (r_in.cmd == CMD_READ && r_rd_ok) ? r_rd_sensed : '0;
    assign o_result.rec_reference = (r_in.cmd == CMD_READ && r_rd_ok) ? r_rd_ref : '0;

endmodule

/* rtl/motor_current_pi_pwm_controller.sv */
// Top level of the motor current PI controller with PWM compare output.
// Depends on mcpi_pkg, mcpi_ctrl and mcpi_dp; holds config and output registers.
//
//  channel   direction  handshake                     payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata 56b, tuser = cmd
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata 64b
//  cfg       in         i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_wdata
//
// A control tick in pwm mode runs only period*duty and the reciprocal multiply;
// in test, hold or track mode it first runs integral, two multipliers and sum.
// Every other word needs no arithmetic. One word is in work at a time.
// Reset is synchronous, active low; the record memory is not cleared.
// A result waiting on m_axis does not stop the next word being accepted;
// that word finishes once the output register is free.
module motor_current_pi_pwm_controller
    import mcpi_pkg::*;
#(
    parameter int RECORD_DEPTH   = 128,
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sensed[15:0], demanded[31:16], new_mode[34:32], duty_request[42:35],
    // sample_index[49:43], zero[55:50]
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // cmd[1:0]
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,
    // pwm_compare[16:0], direction[17], duty_percent[24:18], test_done[25],
    // mode_now[28:26], recorded_sensed[44:29], recorded_reference[60:45],
    // zero[63:61]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [GAIN_W-1:0]     r_prop_gain;
    logic [GAIN_W-1:0]     r_integ_gain;
    logic [LIM_W-1:0]      r_integ_limit;
    logic [CMP_W-1:0]      r_pwm_period;
    logic [AMP_W-1:0]      r_test_amp;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    t_in_word   w_word;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_result    w_res;
    logic       w_in_ready;
    logic       w_out_load;
    logic       w_out_free;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= '0;
            r_integ_gain  <= '0;
            r_integ_limit <= LIM_RST;
            r_pwm_period  <= PERIOD_RST;
            r_test_amp    <= AMP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:  r_prop_gain   <= i_cfg_wdata[GAIN_W-1:0];
                CFG_INTEG_GAIN: r_integ_gain  <= i_cfg_wdata[GAIN_W-1:0];
                CFG_INTEG_LIM:  r_integ_limit <= i_cfg_wdata[LIM_W-1:0];
                CFG_PWM_PERIOD: r_pwm_period  <= i_cfg_wdata[CMP_W-1:0];
                CFG_TEST_AMP:   r_test_amp    <= i_cfg_wdata[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack the input word
    assign w_word.cmd      = t_cmd'(i_s_axis_tuser);
    assign w_word.sensed   = i_s_axis_tdata[15:0];
    assign w_word.demanded = i_s_axis_tdata[31:16];
    assign w_word.new_mode = i_s_axis_tdata[34:32];
    assign w_word.duty_req = i_s_axis_tdata[42:35];
    assign w_word.idx      = i_s_axis_tdata[49:43];

    assign o_s_axis_tready = w_in_ready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    mcpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_out_load (w_out_load),
        .o_cmd      (w_cmd)
    );

    mcpi_dp #(
        .RECORD_DEPTH   (RECORD_DEPTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_word        (w_word),
        .i_prop_gain   (r_prop_gain),
        .i_integ_gain  (r_integ_gain),
        .i_integ_limit (r_integ_limit),
        .i_pwm_period  (r_pwm_period),
        .i_test_amp    (r_test_amp),
        .o_status      (w_status),
        .o_result      (w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {3'b000, w_res.rec_reference, w_res.rec_sensed, w_res.mode,
                           w_res.test_done, w_res.duty, w_res.direction, w_res.compare};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // checks
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.duty <= DUTY_MAX)
        else $error("duty above 100 percent");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second word taken while one is in work");

    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.test_tick <= TEST_LAST_TICK)
        else $error("test tick counter past last tick");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !w_out_load)
        else $error("output word overwritten before taken");

endmodule

/* tb/tb_motor_current_pi_pwm_controller.sv */
// Self-checking testbench for motor_current_pi_pwm_controller: streams command words,
// writes the control registers between phases and checks every result word against a
// cycle-free prediction of the controller state. Depends on mcpi_pkg and the RTL only.
module tb_motor_current_pi_pwm_controller;
    import mcpi_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int RUN_LIMIT     = 6_000_000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_WORDS  = 800;
    localparam int SETTLE_CYCLES = 12;
    localparam int REC_DEPTH     = 128;
    localparam int FRAC_BITS     = 12;
    localparam longint PCT_FULL  = 100;

    // modes with no behaviour of their own
    localparam logic [MODE_W-1:0] MODE_INERT_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_INERT_HI = 3'd7;

    // ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // predicted controller state
    logic [GAIN_W-1:0]       prop_gain_q   = '0;
    logic [GAIN_W-1:0]       integ_gain_q  = '0;
    logic [LIM_W-1:0]        integ_limit_q = LIM_RST;
    logic [CMP_W-1:0]        period_q      = PERIOD_RST;
    logic [AMP_W-1:0]        amplitude_q   = AMP_RST;
    logic [MODE_W-1:0]       mode_q        = MODE_IDLE;
    longint                  integral_q    = 0;
    logic [DUTY_W-1:0]       duty_q        = '0;
    logic                    dir_q         = 1'b0;
    logic [CMP_W-1:0]        compare_q     = COMPARE_RST;
    logic [TICK_W-1:0]       tick_q        = '0;
    logic                    ref_neg_q     = 1'b0;
    logic                    done_q        = 1'b0;
    logic signed [CUR_W-1:0] sensed_log    [REC_DEPTH];
    logic signed [CUR_W-1:0] reference_log [REC_DEPTH];
    bit                      logged        [REC_DEPTH];
    int                      logged_count  = 0;

    t_result expected_words[$];

    // run bookkeeping
    int  errors          = 0;
    int  results_checked = 0;
    int  counted_words   = 0;
    int  reg_writes      = 0;
    int  test_runs       = 0;
    bit  steady_flow     = 1'b0;
    int  ready_left      = 0;

    motor_current_pi_pwm_controller dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- prediction

    // compare = period * duty / 100, integer
    function automatic void refresh_compare();
        longint unsigned prod;
        prod = period_q;
        prod = prod * duty_q;
        compare_q = CMP_W'(prod / 100);
    endfunction

    // one PI update: integrate, clamp, Q4.12 gains, saturate and split sign
    function automatic void pi_update(longint sensed, longint target);
        longint err, lim, kp, ki, u, mag;
        err = target - sensed;
        lim = integ_limit_q;
        kp  = prop_gain_q;
        ki  = integ_gain_q;
        integral_q = integral_q + err;
        if (integral_q > lim) begin
            integral_q = lim;
        end else if (integral_q < -lim) begin
            integral_q = -lim;
        end
        u   = kp * err + ki * integral_q;
        mag = (u < 0) ? -u : u;
        mag = mag >> FRAC_BITS;
        duty_q = (mag > PCT_FULL) ? DUTY_MAX : DUTY_W'(mag);
        dir_q  = (u < 0);
    endfunction

    // advance the predicted state by one accepted command word
    function automatic t_result controller_after(t_in_word w);
        t_result r;
        longint  sensed, demanded, target, req;
        sensed   = $signed(w.sensed);
        demanded = $signed(w.demanded);
        r.rec_sensed    = '0;
        r.rec_reference = '0;
        case (w.cmd)
            CMD_TICK: begin
                if (mode_q == MODE_IDLE) begin
                    compare_q = '0;
                end else if (mode_q == MODE_PWM) begin
                    refresh_compare();
                end else if (mode_q == MODE_TEST) begin
                    target = amplitude_q;
                    if (ref_neg_q) target = -target;
                    done_q = 1'b0;
                    sensed_log[tick_q]    = w.sensed;
                    reference_log[tick_q] = CUR_W'(target);
                    if (!logged[tick_q]) logged_count++;
                    logged[tick_q] = 1'b1;
                    pi_update(sensed, target);
                    refresh_compare();
                    if (tick_q == TEST_FLIP_A || tick_q == TEST_FLIP_B || tick_q == TEST_FLIP_C)
                        ref_neg_q = ~ref_neg_q;
                    if (tick_q == TEST_LAST_TICK) begin
                        done_q     = 1'b1;
                        mode_q     = MODE_IDLE;
                        tick_q     = '0;
                        integral_q = 0;
                        test_runs++;
                    end else begin
                        tick_q = tick_q + 1'b1;
                    end
                end else if (mode_q == MODE_HOLD || mode_q == MODE_TRACK) begin
                    pi_update(sensed, demanded);
                    refresh_compare();
                end
            end
            CMD_MODE_SEL: begin
                mode_q = w.new_mode;
                if (w.new_mode == MODE_TEST) done_q = 1'b0;
            end
            CMD_SET_DUTY: begin
                req   = $signed(w.duty_req);
                dir_q = (req < 0);
                if (req > PCT_FULL) req = PCT_FULL;
                if (req < -PCT_FULL) req = -PCT_FULL;
                duty_q = DUTY_W'((req < 0) ? -req : req);
            end
            default: begin
                r.rec_sensed    = sensed_log[w.idx];
                r.rec_reference = reference_log[w.idx];
            end
        endcase
        r.compare   = compare_q;
        r.direction = dir_q;
        r.duty      = duty_q;
        r.test_done = done_q;
        r.mode      = mode_q;
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string field, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch in result word %0d, %s: expected 0x%0h, got 0x%0h",
                         results_checked, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result word 0x%0h arrived with none expected", o_m_axis_tdata);
            end else begin
                want = expected_words.pop_front();
                check_field("pwm_compare",        want.compare,       o_m_axis_tdata[16:0]);
                check_field("direction",          want.direction,     o_m_axis_tdata[17]);
                check_field("duty_percent",       want.duty,          o_m_axis_tdata[24:18]);
                check_field("test_done",          want.test_done,     o_m_axis_tdata[25]);
                check_field("mode_now",           want.mode,          o_m_axis_tdata[28:26]);
                check_field("recorded_sensed",    want.rec_sensed,    o_m_axis_tdata[44:29]);
                check_field("recorded_reference", want.rec_reference, o_m_axis_tdata[60:45]);
                check_field("zero pad",           0,                  o_m_axis_tdata[63:61]);
                results_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- sink stalls

    // mostly ready, short stalls, now and then a long one
    always @(posedge i_clk) begin
        int roll;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            ready_left      <= 0;
        end else if (steady_flow) begin
            i_m_axis_tready <= 1'b1;
        end else if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else begin
            roll = $urandom_range(19);
            if (roll < 12) begin
                i_m_axis_tready <= 1'b1;
                ready_left      <= $urandom_range(12);
            end else if (roll < 18) begin
                i_m_axis_tready <= 1'b0;
                ready_left      <= $urandom_range(2);
            end else begin
                i_m_axis_tready <= 1'b0;
                ready_left      <= $urandom_range(40, 10);
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    function automatic int sender_gap();
        int roll;
        if (steady_flow) return 0;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // send one command word; tvalid stays high when no gap follows
    task automatic send_word(t_in_word w);
        int gap;
        i_s_axis_tdata  <= {6'd0, w.idx, w.duty_req, w.new_mode, w.demanded, w.sensed};
        i_s_axis_tuser  <= w.cmd;
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!(i_s_axis_tvalid && o_s_axis_tready)) @(posedge i_clk);
        if (!(w.cmd == CMD_TICK && mode_q > MODE_TRACK)) counted_words++;
        expected_words.push_back(controller_after(w));
        gap = sender_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and wait until every result word has come back
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready)) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_PROP_GAIN:  prop_gain_q   = value[GAIN_W-1:0];
            CFG_INTEG_GAIN: integ_gain_q  = value[GAIN_W-1:0];
            CFG_INTEG_LIM:  integ_limit_q = value[LIM_W-1:0];
            CFG_PWM_PERIOD: period_q      = value[CMP_W-1:0];
            CFG_TEST_AMP:   amplitude_q   = value[AMP_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    // word with every field random, unused fields included
    function automatic t_in_word filler_word(t_cmd c);
        t_in_word w;
        w.cmd      = c;
        w.sensed   = CUR_W'($urandom);
        w.demanded = CUR_W'($urandom);
        w.new_mode = MODE_W'($urandom_range(7));
        w.duty_req = DREQ_W'($urandom);
        w.idx      = IDX_W'($urandom_range(REC_DEPTH - 1));
        return w;
    endfunction

    function automatic logic [IDX_W-1:0] logged_index();
        logic [IDX_W-1:0] idx;
        do idx = IDX_W'($urandom_range(REC_DEPTH - 1)); while (!logged[idx]);
        return idx;
    endfunction

    task automatic do_tick(logic [CUR_W-1:0] sensed, logic [CUR_W-1:0] demanded);
        t_in_word w;
        w = filler_word(CMD_TICK);
        w.sensed   = sensed;
        w.demanded = demanded;
        send_word(w);
    endtask

    task automatic do_mode(logic [MODE_W-1:0] m);
        t_in_word w;
        w = filler_word(CMD_MODE_SEL);
        w.new_mode = m;
        send_word(w);
    endtask

    task automatic do_duty(logic [DREQ_W-1:0] d);
        t_in_word w;
        w = filler_word(CMD_SET_DUTY);
        w.duty_req = d;
        send_word(w);
    endtask

    task automatic do_read(logic [IDX_W-1:0] idx);
        t_in_word w;
        w = filler_word(CMD_READ);
        w.idx = idx;
        send_word(w);
    endtask

    // sensed current loosely following the square-wave reference
    function automatic logic [CUR_W-1:0] follow_current();
        int target;
        target = amplitude_q;
        if (ref_neg_q) target = -target;
        return CUR_W'(target * 3 / 4 + int'($urandom_range(127)) - 64);
    endfunction

    // ---------------------------------------------------------------- tests

    // idle, pwm, set-duty saturation and inert modes at reset settings, then one hold tick
    task automatic test_command_basics();
        do_mode(MODE_IDLE);
        do_tick(CUR_W'($urandom), CUR_W'($urandom));
        do_duty(8'sd127);
        do_duty(-8'sd128);
        do_duty(8'sd101);
        do_duty(-8'sd1);
        do_mode(MODE_PWM);
        do_tick(CUR_W'($urandom), CUR_W'($urandom));
        do_duty(-8'sd100);
        do_tick(CUR_W'($urandom), CUR_W'($urandom));
        do_duty(8'sd0);
        do_tick(CUR_W'($urandom), CUR_W'($urandom));
        do_mode(MODE_INERT_LO);
        do_tick(16'h8000, 16'h7fff);
        do_mode(MODE_INERT_HI);
        do_tick(16'h7fff, 16'h8000);
        // tiny negative output: direction bit set with zero duty
        settle();
        write_reg(CFG_PROP_GAIN, 20'd1);
        do_mode(MODE_HOLD);
        do_tick(16'd1, 16'd0);
    endtask

    // register extremes: full gains, pinned integral, zero and largest periods
    task automatic test_register_extremes();
        settle();
        write_reg(CFG_PROP_GAIN, 20'hffff);
        write_reg(CFG_INTEG_GAIN, 20'hffff);
        write_reg(CFG_INTEG_LIM, 20'd0);
        write_reg(CFG_PWM_PERIOD, 20'h1ffff);
        write_reg(CFG_TEST_AMP, 20'h7fff);
        do_mode(MODE_TRACK);
        do_tick(16'h8000, 16'h7fff);
        do_tick(16'h7fff, 16'h8000);
        do_tick(16'd0, 16'd0);
        settle();
        write_reg(CFG_INTEG_LIM, 20'hfffff);
        write_reg(CFG_PROP_GAIN, 20'd0);
        write_reg(CFG_INTEG_GAIN, 20'd1);
        write_reg(CFG_PWM_PERIOD, 20'd0);
        repeat (3) do_tick(16'h8000, 16'h7fff);
        settle();
        write_reg(CFG_PWM_PERIOD, 20'd65536);
        do_mode(MODE_PWM);
        do_duty(8'sd100);
        do_tick(16'd0, 16'd0);
        settle();
        write_reg(CFG_PWM_PERIOD, 20'd1);
        do_tick(16'd0, 16'd0);
    endtask

    // full square-wave run, read-back, flag clearing and an interrupted run
    task automatic test_square_wave();
        int stop_at;
        settle();
        write_reg(CFG_PROP_GAIN, 20'd2048);
        write_reg(CFG_INTEG_GAIN, 20'd256);
        write_reg(CFG_INTEG_LIM, 20'd1600);
        write_reg(CFG_PWM_PERIOD, 20'd4000);
        write_reg(CFG_TEST_AMP, 20'd200);
        do_mode(MODE_TEST);
        while (mode_q == MODE_TEST) do_tick(follow_current(), CUR_W'($urandom));
        do_tick(CUR_W'($urandom), CUR_W'($urandom));
        do_read(IDX_W'(0));
        do_read(TEST_FLIP_A);
        do_read(TEST_FLIP_A + 1'b1);
        do_read(TEST_FLIP_C + 1'b1);
        do_read(TEST_LAST_TICK);
        repeat (6) do_read(logged_index());
        // entering test clears the finished flag
        do_mode(MODE_TEST);
        stop_at = $urandom_range(60, 10);
        repeat (stop_at) do_tick(follow_current(), CUR_W'($urandom));
        do_mode(MODE_HOLD);
        repeat (3) do_tick(CUR_W'($urandom_range(300)), CUR_W'(150));
        do_mode(MODE_TEST);
        while (mode_q == MODE_TEST) do_tick(follow_current(), CUR_W'($urandom));
    endtask

    task automatic random_registers();
        logic [CFG_DATA_W-1:0] v;
        int roll;
        settle();
        roll = $urandom_range(7);
        v = (roll == 0) ? 20'd0 : (roll == 1) ? 20'hffff :
            (roll == 2) ? CFG_DATA_W'($urandom_range(65535)) : CFG_DATA_W'($urandom_range(4096));
        write_reg(CFG_PROP_GAIN, v);
        roll = $urandom_range(7);
        v = (roll == 0) ? 20'd0 : (roll == 1) ? 20'hffff :
            (roll == 2) ? CFG_DATA_W'($urandom_range(65535)) : CFG_DATA_W'($urandom_range(512));
        write_reg(CFG_INTEG_GAIN, v);
        roll = $urandom_range(7);
        v = (roll == 0) ? 20'd0 : (roll == 1) ? 20'hfffff :
            (roll == 2) ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(20000, 50));
        write_reg(CFG_INTEG_LIM, v);
        roll = $urandom_range(7);
        v = (roll == 0) ? 20'd0 : (roll == 1) ? 20'h1ffff :
            (roll == 2) ? CFG_DATA_W'($urandom_range(131071)) : CFG_DATA_W'($urandom_range(65536, 1));
        write_reg(CFG_PWM_PERIOD, v);
        roll = $urandom_range(7);
        v = (roll == 0) ? 20'd0 : (roll == 1) ? 20'h7fff :
            (roll == 2) ? CFG_DATA_W'($urandom_range(32767)) : CFG_DATA_W'($urandom_range(2000));
        write_reg(CFG_TEST_AMP, v);
    endtask

    // mostly well-formed control sequences with random content, plus noise words
    task automatic test_random_mix();
        int goal, n, target, spread;
        t_in_word w;
        goal = counted_words + RANDOM_WORDS;
        while (counted_words < goal) begin
            steady_flow = ($urandom_range(5) == 0);
            case ($urandom_range(9))
                0: random_registers();
                1, 2: begin
                    do_mode(MODE_TEST);
                    n = ($urandom_range(2) == 0) ? $urandom_range(100, 10) : 100;
                    while (n > 0 && mode_q == MODE_TEST) begin
                        do_tick(follow_current(), CUR_W'($urandom));
                        n--;
                    end
                end
                3, 4: begin
                    do_mode(($urandom_range(1) == 0) ? MODE_HOLD : MODE_TRACK);
                    target = int'($urandom_range(4000)) - 2000;
                    spread = 1 << $urandom_range(9);
                    repeat ($urandom_range(40, 5)) begin
                        if ($urandom_range(7) == 0)
                            do_tick(CUR_W'($urandom), CUR_W'($urandom));
                        else
                            do_tick(CUR_W'(target + int'($urandom_range(2 * spread)) - spread),
                                    CUR_W'(target));
                        if (mode_q == MODE_TRACK)
                            target = target + int'($urandom_range(100)) - 50;
                    end
                end
                5: begin
                    do_mode(MODE_PWM);
                    do_duty(DREQ_W'($urandom));
                    repeat ($urandom_range(6, 1)) do_tick(CUR_W'($urandom), CUR_W'($urandom));
                end
                6: begin
                    if (logged_count > 0)
                        repeat ($urandom_range(8, 1)) do_read(logged_index());
                end
                default: begin
                    repeat ($urandom_range(15, 1)) begin
                        w = filler_word(t_cmd'($urandom_range(3)));
                        if (w.cmd == CMD_READ) begin
                            if (logged_count > 0) w.idx = logged_index();
                            else w.cmd = CMD_SET_DUTY;
                        end
                        send_word(w);
                    end
                end
            endcase
        end
        steady_flow = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_command_basics();
        test_register_extremes();
        test_square_wave();
        test_random_mix();
        settle();
        $display("run covered %0d command words and %0d checked results, %0d register writes",
                 counted_words, results_checked, reg_writes);
        $display("square-wave tests completed: %0d, record entries written: %0d, errors: %0d",
                 test_runs, logged_count, errors);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #RUN_LIMIT;
        $display("timeout with %0d result words outstanding", expected_words.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
